// ===== hw/rtl/asmlt_pkg.sv =====
// Shared types and constants for the assembly line tokenizer.
// Character codes, token kinds, control states and the request structs.
// No dependencies.
package asmlt_pkg;

	localparam int unsigned MAX_TOKEN_LEN_DEF = 64;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef enum logic [1:0] {
		KIND_LABEL   = 2'd0,
		KIND_OPCODE  = 2'd1,
		KIND_OPERAND = 2'd2,
		KIND_COMMENT = 2'd3
	} kind_t;

	typedef enum logic {
		ST_COLLECT,
		ST_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] token_char;
		logic [1:0] token_kind;
		logic       token_last;
		logic       token_truncated;
	} token_item_t;

	typedef struct packed {
		logic [1:0] token_kind;
		logic       token_last;
		logic       token_truncated;
	} token_meta_t;

endpackage

// ===== hw/rtl/asmlt_buf.sv =====
// Token character store: one write port, one registered read port.
// Depends on nothing but its parameter.
module asmlt_buf #(
	parameter int unsigned MAX_TOKEN_LEN = 64,
	localparam int unsigned AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data_s1
);

	logic [7:0] mem [MAX_TOKEN_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data between reads so it can wait for the output stage
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/asmlt_ctrl.sv =====
// Line mode tracking, break decoding and token drain sequencing.
// Depends on asmlt_pkg; drives the write and read ports of asmlt_buf.
module asmlt_ctrl #(
	parameter int unsigned MAX_TOKEN_LEN = 64,
	localparam int unsigned AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  asmlt_pkg::byte_item_t  byte_data,
	input  logic                   out_ready,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [7:0]             wr_data,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	output logic                   rd_valid_s1,
	output asmlt_pkg::token_meta_t meta_s1
);

	import asmlt_pkg::*;

	localparam int unsigned LW = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);

	ctrl_state_t   state_q, state_d;
	kind_t         mode_q, mode_d;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic [LW-1:0] drain_len_q;
	kind_t         drain_kind_q;
	logic          drain_trunc_q;
	logic [LW-1:0] rd_ptr_q;
	logic [LW-1:0] rd_ptr_nx;

	logic  accept;
	logic  flush;
	logic  append;
	kind_t flush_kind;
	logic  issue;
	logic  last_issue;

	assign accept     = byte_valid && !byte_stall;
	assign rd_ptr_nx  = rd_ptr_q + LW'(1);
	assign last_issue = (rd_ptr_nx == drain_len_q);

	// break decode for the current byte
	always_comb begin
		flush      = 1'b0;
		append     = 1'b0;
		flush_kind = mode_q;
		mode_d     = mode_q;
		case (byte_data.in_byte)
			CH_SEMI: begin
				mode_d = KIND_COMMENT;
			end
			CH_COLON: begin
				if (mode_q == KIND_LABEL) begin
					flush      = 1'b1;
					flush_kind = KIND_LABEL;
					mode_d     = KIND_OPCODE;
				end
			end
			CH_SPACE, CH_TAB: begin
				if (len_q != '0 && (mode_q inside {KIND_LABEL, KIND_OPCODE})) begin
					flush      = 1'b1;
					flush_kind = KIND_OPCODE;
					mode_d     = KIND_OPERAND;
				end
			end
			CH_COMMA: begin
				if (mode_q == KIND_OPERAND) begin
					flush      = 1'b1;
					flush_kind = KIND_OPERAND;
				end
			end
			CH_LF: begin
				flush      = 1'b1;
				flush_kind = (mode_q inside {KIND_LABEL, KIND_OPCODE}) ? KIND_OPCODE : mode_q;
				mode_d     = KIND_LABEL;
			end
			CH_CR: begin
				mode_d = mode_q;
			end
			default: begin
				append = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (accept && flush && len_q != '0) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue && last_issue) begin
					state_d = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	// outputs
	always_comb begin
		byte_stall = (state_q != ST_COLLECT);
		issue      = (state_q == ST_DRAIN) && (!rd_valid_s1 || out_ready);
		rd_en      = issue;
		rd_addr    = rd_ptr_q[AW-1:0];
		wr_en      = accept && append && (len_q < MAX_LEN);
		wr_addr    = len_q[AW-1:0];
		wr_data    = byte_data.in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			mode_q      <= KIND_LABEL;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			rd_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				// end of text drops pending text; a started drain still runs
				if (byte_data.end_of_text) begin
					mode_q <= KIND_LABEL;
					len_q  <= '0;
					ovf_q  <= 1'b0;
				end else begin
					mode_q <= mode_d;
					if (flush) begin
						len_q <= '0;
						ovf_q <= 1'b0;
					end else if (append) begin
						if (len_q < MAX_LEN) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
			end
			if (issue) begin
				rd_ptr_q <= last_issue ? '0 : rd_ptr_nx;
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (out_ready) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && flush) begin
			drain_len_q   <= len_q;
			drain_kind_q  <= flush_kind;
			drain_trunc_q <= ovf_q;
		end
		if (issue) begin
			meta_s1.token_kind      <= drain_kind_q;
			meta_s1.token_last      <= last_issue;
			meta_s1.token_truncated <= drain_trunc_q;
		end
	end

endmodule

// ===== hw/rtl/asmlt_out.sv =====
// Output register stage for token characters.
// Depends on asmlt_pkg for the result and metadata structs.
module asmlt_out (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_valid_s1,
	input  logic [7:0]             rd_data_s1,
	input  asmlt_pkg::token_meta_t meta_s1,
	output logic                   out_ready,
	output logic                   token_valid,
	input  logic                   token_stall,
	output asmlt_pkg::token_item_t token_data
);

	import asmlt_pkg::*;

	logic load;

	assign out_ready = !token_valid || !token_stall;
	assign load      = rd_valid_s1 && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid <= 1'b0;
		end else if (out_ready) begin
			token_valid <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			token_data.token_char      <= rd_data_s1;
			token_data.token_kind      <= meta_s1.token_kind;
			token_data.token_last      <= meta_s1.token_last;
			token_data.token_truncated <= meta_s1.token_truncated;
		end
	end

endmodule

// ===== hw/rtl/asm_line_tokenizer_core.sv =====
// Top level of the assembly line tokenizer.
// Depends on asmlt_pkg, asmlt_buf, asmlt_ctrl and asmlt_out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   byte    | in        | byte_valid/stall     | in_byte, end_of_text
//   token   | out       | token_valid/stall    | char, kind, last, truncated
//
// Flow: a byte that does not end a token leaves byte_stall low. A byte that ends
//   a token then holds byte_stall high while the token store is read out, one
//   character per cycle through its single read port while token_stall is low;
//   token_stall lengthens the hold.
// Reset: arst_n clears mode, length, overflow and all valid flags; the token
//   store itself is not cleared, only entries below the length are read.
// Stalls: the output register takes a new character whenever it is empty or
//   being taken, so a token streams at one character per cycle while token_stall is low.
module asm_line_tokenizer_core #(
	parameter int unsigned MAX_TOKEN_LEN = asmlt_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  asmlt_pkg::byte_item_t  byte_data,
	output logic                   token_valid,
	input  logic                   token_stall,
	output asmlt_pkg::token_item_t token_data
);

	import asmlt_pkg::*;

	localparam int unsigned AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data_s1;
	logic          rd_valid_s1;
	token_meta_t   meta_s1;
	logic          out_ready;

	// Decode breaks, track the line mode and sequence the readout. Writes
	// only happen while collecting and reads only while draining, so the
	// store never sees a read and a write to the same entry in one cycle.
	asmlt_ctrl #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.out_ready  (out_ready),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_valid_s1(rd_valid_s1),
		.meta_s1    (meta_s1)
	);

	// Token characters live here; read data is registered and held.
	asmlt_buf #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_buf (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_s1(rd_data_s1)
	);

	// Output register: decouples the read stage from token_stall.
	asmlt_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid_s1(rd_valid_s1),
		.rd_data_s1 (rd_data_s1),
		.meta_s1    (meta_s1),
		.out_ready  (out_ready),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_data (token_data)
	);

	// store is never written and read in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("token store written and read in the same cycle");

	// reads only happen while input is held off
	a_read_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> byte_stall)
		else $error("token store read while input requests are taken");

	// every read lands in the read stage
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> rd_valid_s1)
		else $error("issued read did not reach the read stage");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for asm_line_tokenizer_core: random assembly lines in, token streams out.
// Depends on asmlt_pkg for the request and token structs, the character codes and the kinds.
module testbench;
	import asmlt_pkg::*;

	localparam int unsigned TOKEN_CAP = MAX_TOKEN_LEN_DEF;
	localparam int ITEM_TARGET = 430;
	// Cycles with no handshake on either channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Settle time after the last expected character: one full token drain and margin.
	localparam int TAIL_CYCLES = 2 * TOKEN_CAP + 16;

	// Mirror of the tokenizer: line mode, token store, length and overflow flag,
	// plus the queue of token characters still owed by the block.
	class token_scoreboard;
		kind_t       mode = KIND_LABEL;
		logic [7:0]  held [TOKEN_CAP];
		logic [6:0]  held_len = '0;
		logic        overflowed = 1'b0;
		token_item_t owed_chars [$];
		int          errors = 0;
		int          chars_seen = 0;
		int          tokens_seen = 0;
		int          cut_tokens = 0;

		// Queue the stored text as one token and empty the store.
		function void emit_token(kind_t kind);
			for (int i = 0; i < held_len; i++)
				owed_chars.push_back(token_item_t'{held[i], kind, i == held_len - 1, overflowed});
			held_len = '0;
			overflowed = 1'b0;
		endfunction

		function void note_byte(byte_item_t item);
			case (item.in_byte)
				CH_SEMI: mode = KIND_COMMENT;
				CH_COLON: if (mode == KIND_LABEL) begin
					emit_token(KIND_LABEL);
					mode = KIND_OPCODE;
				end
				CH_SPACE, CH_TAB: if (held_len != 0 &&
						(mode == KIND_LABEL || mode == KIND_OPCODE)) begin
					emit_token(KIND_OPCODE);
					mode = KIND_OPERAND;
				end
				CH_COMMA: if (mode == KIND_OPERAND)
					emit_token(KIND_OPERAND);
				CH_LF: begin
					emit_token((mode == KIND_LABEL || mode == KIND_OPCODE) ? KIND_OPCODE : mode);
					mode = KIND_LABEL;
				end
				CH_CR: ;
				default: if (held_len < TOKEN_CAP) begin
					held[held_len] = item.in_byte;
					held_len++;
				end else begin
					overflowed = 1'b1;
				end
			endcase
			// End of text drops whatever is pending.
			if (item.end_of_text) begin
				mode = KIND_LABEL;
				held_len = '0;
				overflowed = 1'b0;
			end
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_token(token_item_t got);
			token_item_t want;
			if (owed_chars.size() == 0) begin
				$error("token character %02h arrived with nothing owed", got.token_char);
				errors++;
				return;
			end
			want = owed_chars.pop_front();
			compare_field("token_char", want.token_char, got.token_char);
			compare_field("token_kind", want.token_kind, got.token_kind);
			compare_field("token_last", want.token_last, got.token_last);
			compare_field("token_truncated", want.token_truncated, got.token_truncated);
			chars_seen++;
			if (got.token_last) begin
				tokens_seen++;
				if (got.token_truncated)
					cut_tokens++;
			end
		endfunction

		function int pending();
			return owed_chars.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	byte_item_t  byte_data = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	token_item_t token_data;

	token_scoreboard sb;
	byte_item_t      line_q [$];
	int              bytes_sent = 0;
	int              burst_left = 0;
	int              gap_max = 0;
	int              stall_pct = 0;
	int              stall_run = 0;
	logic            stall_level = 1'b0;
	int              idle_cycles = 0;

	asm_line_tokenizer_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_data (token_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: hold stall at one level for a random run, then pick again.
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_run = $urandom_range(1, 8);
			stall_level = ($urandom_range(99) < stall_pct);
		end
		stall_run--;
		token_stall <= stall_level;
	end

	// Sample both channels at the rising edge; inputs only move on the falling one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				sb.note_byte(byte_data);
			if (token_valid && !token_stall)
				sb.check_token(token_data);
			if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			// Watchdog: no request and no token character for too long.
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Present one request and hold it until taken; open a gap between bursts.
	task automatic send_byte(byte_item_t item);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk) byte_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_data <= item;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
	endtask

	// Drop valid and wait until every owed token character has come out.
	task automatic drain();
		@(negedge clk) byte_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	function automatic void push_char(logic [7:0] c);
		line_q.push_back(byte_item_t'{c, 1'b0});
	endfunction

	function automatic void push_blanks(int lo, int hi);
		repeat ($urandom_range(lo, hi))
			push_char($urandom_range(1) ? CH_SPACE : CH_TAB);
	endfunction

	// Append one word: mostly short alphanumerics, now and then long enough to overflow,
	// sometimes with arbitrary non-break bytes including ones above ASCII.
	function automatic void add_word();
		int n;
		logic [7:0] c;
		n = ($urandom_range(99) < 4) ? $urandom_range(TOKEN_CAP - 4, TOKEN_CAP + 6)
			: $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(9) < 8) begin
				c = ($urandom_range(3) == 0) ? 8'($urandom_range(48, 57))
					: 8'($urandom_range(97, 122));
			end else begin
				do c = 8'($urandom);
				while (c inside {CH_SEMI, CH_COLON, CH_SPACE, CH_TAB, CH_COMMA, CH_LF, CH_CR});
			end
			push_char(c);
		end
	endfunction

	initial begin
		logic [7:0] opening [] = '{"a", 8'hFF, CH_COLON, 8'h00, CH_TAB, CH_SPACE, "x",
			CH_COMMA, "y", CH_CR, CH_COMMA, CH_COLON, "z", CH_SEMI, "q", CH_LF, "k",
			CH_COMMA, CH_LF, CH_SPACE, "w", CH_LF, CH_LF, "p"};
		int lines = 0;
		int phase = 0;
		int r;
		int cut;
		logic [7:0] c;

		sb = new;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Opening lines: label with a high byte, opcode of a zero byte, blank in empty buffer,
		// operands with a carriage return inside, stray colon and comma, comment that swallows
		// buffered text, empty line, and a pending word dropped by end of text.
		gap_max = 2;
		stall_pct = 20;
		foreach (opening[i])
			send_byte(byte_item_t'{opening[i], i == opening.size() - 1});
		drain();

		while (bytes_sent < ITEM_TARGET) begin
			// Switch idling profile every few lines; wait for the block to go idle first.
			if (lines % 8 == 0) begin
				drain();
				phase++;
				case (phase % 4)
					0: begin gap_max = 0; stall_pct = 0; end
					1: begin gap_max = 3; stall_pct = 30; end
					2: begin gap_max = 12; stall_pct = 60; end
					default: begin gap_max = 0; stall_pct = 75; end
				endcase
			end
			lines++;
			line_q.delete();
			r = $urandom_range(99);
			if (r < 8) begin
				// Noise: raw bytes, any value, end of text now and then.
				repeat ($urandom_range(1, 12))
					line_q.push_back(byte_item_t'{8'($urandom), $urandom_range(9) == 0});
			end else begin
				if ($urandom_range(1)) begin
					add_word();
					push_char(CH_COLON);
				end
				push_blanks(0, 2);
				if ($urandom_range(99) < 85) begin
					add_word();
					if ($urandom_range(99) < 80) begin
						push_blanks(1, 2);
						add_word();
						repeat ($urandom_range(0, 2)) begin
							push_char(CH_COMMA);
							if ($urandom_range(3) == 0)
								push_char(CH_SPACE);
							add_word();
						end
					end
				end
				if ($urandom_range(99) < 30) begin
					push_char(CH_SEMI);
					repeat ($urandom_range(0, 10)) begin
						do c = 8'($urandom); while (c == CH_LF);
						push_char(c);
					end
				end
				r = $urandom_range(99);
				if (r < 10) begin
					push_char(CH_CR);
					push_char(CH_LF);
				end else if (r < 95) begin
					push_char(CH_LF);
				end
				// Break a few lines off with end of text, or end the text on a full line.
				if (line_q.size() > 0) begin
					if ($urandom_range(99) < 6) begin
						cut = $urandom_range(0, line_q.size() - 1);
						while (line_q.size() > cut + 1) void'(line_q.pop_back());
						line_q[cut].end_of_text = 1'b1;
					end else if ($urandom_range(99) < 4) begin
						line_q[line_q.size() - 1].end_of_text = 1'b1;
					end
				end
			end
			foreach (line_q[i])
				send_byte(line_q[i]);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d bytes over %0d lines; checked %0d tokens, %0d characters,",
			bytes_sent, lines, sb.tokens_seen, sb.chars_seen);
		$display("of which %0d tokens came out truncated.", sb.cut_tokens);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (sb.pending() != 0)
				$error("%0d token characters never arrived", sb.pending());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
